>>> hdl/kxbc_pkg.sv
`default_nettype none

package kxbc_pkg;

  // Input tdata layout, lowest bit first
  localparam int InDataW   = 16;
  localparam int FuncLsb   = 0;
  localparam int FuncW     = 2;
  localparam int IndexLsb  = 2;
  localparam int IndexW    = 5;
  localparam int ValueLsb  = 7;
  localparam int ByteW     = 8;
  localparam int FirstBit  = 15;
  localparam int PassLenW  = 6;

  // Command codes carried in the func field
  localparam logic [FuncW-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FuncW-1:0] FUNC_APPLY  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_CIPHER = 2'd2;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CIPH = 4'b0010,
    ST_STEP = 4'b0100,
    ST_KEY  = 4'b1000
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic pass_wr;      // store password byte from input
    logic cipher_rd;    // read key byte for a data byte
    logic out_load;     // load result register, advance key position
    logic apply_start;  // start key derivation walk
    logic step;         // one password byte through the derivation
    logic key_wb;       // write derived key byte back
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic len_zero;
    logic last_j;
    logic last_i;
    logic out_free;
  } status_t;

  // Power-up key pattern: low byte of ((i*i+i+1)<<3)
  function automatic logic [7:0] key_init(input logic [7:0] idx);
    logic [7:0] s;
    s = idx * idx + idx + 8'd1;
    return {s[4:0], 3'b000};
  endfunction

endpackage

`default_nettype wire

>>> hdl/keyed_xor_byte_cipher_top.sv
// Repeating-key XOR byte cipher.
// Slave stream s_axis carries commands: func 0 stores a password byte at
// index, func 1 folds the password into the key table, func 2 enciphers one
// data byte with the key at a running position (first restarts it at 0).
// func 3 is ignored. Only func 2 yields a transfer on master stream m_axis.
// cfg_we_i/cfg_wdata_i write pass_len; write it only while the block is idle,
// which the block itself does not enforce. Handshake by command:
//   func 0, func 3, func 1 with pass_len 0: taken in idle, input stays ready.
//   func 2: the key byte and the data byte are registered, then the result
//     register is loaded and input is ready again; a new data byte waits for
//     that. The key table has a single registered read port.
//   func 1: busy while each key entry, L = min(pass_len, MAX_PASS), walks
//     the password through one registered memory read a cycle.
// A result waiting on a stalled m_axis does not block new transfers; a second
// func 2 then waits in the controller until the result register frees up.
// Reset: key table back to its power-up pattern, key position 0, pass_len 0.
// The password store keeps its contents and must be written before use.
`default_nettype none

module keyed_xor_byte_cipher_top #(
  parameter int KEY_LEN  = 32,
  parameter int MAX_PASS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [1:0] func, [6:2] index, [14:7] value, [15] first
  input  wire logic [kxbc_pkg::InDataW-1:0]        s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [7:0] data_out
  output logic [kxbc_pkg::ByteW-1:0]               m_axis_tdata,
  input  wire logic                                cfg_we_i,
  input  wire logic [kxbc_pkg::PassLenW-1:0]       cfg_wdata_i
);

  kxbc_pkg::cmd_t    cmd;
  kxbc_pkg::status_t status;

  kxbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tdata[kxbc_pkg::FuncLsb +: kxbc_pkg::FuncW]),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kxbc_datapath #(
    .KEY_LEN  (KEY_LEN),
    .MAX_PASS (MAX_PASS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_index_i  (s_axis_tdata[kxbc_pkg::IndexLsb +: kxbc_pkg::IndexW]),
    .in_value_i  (s_axis_tdata[kxbc_pkg::ValueLsb +: kxbc_pkg::ByteW]),
    .in_first_i  (s_axis_tdata[kxbc_pkg::FirstBit]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> hdl/kxbc_ctrl.sv
`default_nettype none

module kxbc_ctrl (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire logic [kxbc_pkg::FuncW-1:0]        in_func_i,
  output logic                                   in_ready_o,
  input  wire kxbc_pkg::status_t                 status_i,
  output kxbc_pkg::cmd_t                         cmd_o
);

  kxbc_pkg::state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      kxbc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_func_i)
            kxbc_pkg::FUNC_LOAD: begin
              cmd_o.pass_wr = 1'b1;
            end
            kxbc_pkg::FUNC_APPLY: begin
              if (!status_i.len_zero) begin
                cmd_o.apply_start = 1'b1;
                state_d           = kxbc_pkg::ST_STEP;
              end
            end
            kxbc_pkg::FUNC_CIPHER: begin
              cmd_o.cipher_rd = 1'b1;
              state_d         = kxbc_pkg::ST_CIPH;
            end
            default: begin
            end
          endcase
        end
      end
      kxbc_pkg::ST_CIPH: begin
        // wait for room in the result register
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = kxbc_pkg::ST_IDLE;
        end
      end
      kxbc_pkg::ST_STEP: begin
        cmd_o.step = 1'b1;
        if (status_i.last_j) begin
          state_d = kxbc_pkg::ST_KEY;
        end
      end
      kxbc_pkg::ST_KEY: begin
        cmd_o.key_wb = 1'b1;
        if (status_i.last_i) begin
          state_d = kxbc_pkg::ST_IDLE;
        end else begin
          state_d = kxbc_pkg::ST_STEP;
        end
      end
      default: begin
        state_d = kxbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kxbc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/kxbc_datapath.sv
`default_nettype none

module kxbc_datapath #(
  parameter int KEY_LEN  = 32,
  parameter int MAX_PASS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [kxbc_pkg::IndexW-1:0]         in_index_i,
  input  wire logic [kxbc_pkg::ByteW-1:0]          in_value_i,
  input  wire logic                                in_first_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [kxbc_pkg::PassLenW-1:0]       cfg_wdata_i,
  input  wire kxbc_pkg::cmd_t                      cmd_i,
  output kxbc_pkg::status_t                        status_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [kxbc_pkg::ByteW-1:0]               out_data_o
);

  localparam int KA_W  = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
  localparam int PA_W  = (MAX_PASS > 1) ? $clog2(MAX_PASS) : 1;
  localparam int LEN_W = $clog2(MAX_PASS + 1);
  localparam logic [KA_W-1:0] KeyLast = KA_W'(KEY_LEN - 1);

  // Stores
  logic [7:0]          key_mem  [KEY_LEN];
  logic [7:0]          pass_mem [MAX_PASS];
  logic [KEY_LEN-1:0]  key_vld_q;

  // Read ports
  logic                key_re;
  logic [KA_W-1:0]     key_raddr;
  logic [KA_W-1:0]     key_raddr_q;
  logic [7:0]          key_rdata_q;
  logic                key_rvld_q;
  logic [7:0]          key_eff;
  logic                pass_re;
  logic [PA_W-1:0]     pass_raddr;
  logic [7:0]          pass_rdata_q;
  logic                pass_we;

  // Control registers and counters
  logic [kxbc_pkg::PassLenW-1:0] pass_len_q;
  logic [6:0]          plen_ext;
  logic [LEN_W-1:0]    len_eff;
  logic [LEN_W-1:0]    len_m1;
  logic [KA_W-1:0]     key_pos_q, key_pos_d;
  logic [KA_W-1:0]     pos_sel;
  logic [KA_W-1:0]     i_q, i_d;
  logic [PA_W-1:0]     k_q, k_d, k_next;
  logic [PA_W-1:0]     j_q, j_d;
  logic [7:0]          c_q, c_d;
  logic [7:0]          value_q;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_data_q;

  // Effective password length, saturated at MAX_PASS
  assign plen_ext = 7'(pass_len_q);
  assign len_eff  = (plen_ext > 7'(MAX_PASS)) ? LEN_W'(MAX_PASS) : LEN_W'(plen_ext);
  assign len_m1   = len_eff - LEN_W'(1);

  assign status_o.len_zero = (len_eff == '0);
  assign status_o.last_j   = (LEN_W'(j_q) == len_m1);
  assign status_o.last_i   = (i_q == KeyLast);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Key byte: stored value once written, power-up pattern before
  assign key_eff = key_rvld_q ? key_rdata_q : kxbc_pkg::key_init(8'(key_raddr_q));

  assign pos_sel   = in_first_i ? '0 : key_pos_q;
  assign key_re    = cmd_i.cipher_rd || (cmd_i.step && status_o.last_j);
  assign key_raddr = cmd_i.cipher_rd ? pos_sel : i_q;

  assign pass_we    = cmd_i.pass_wr && (int'(in_index_i) < MAX_PASS);
  assign pass_re    = cmd_i.apply_start || cmd_i.key_wb ||
                      (cmd_i.step && !status_o.last_j);
  assign pass_raddr = cmd_i.step ? (j_q + PA_W'(1)) : '0;

  assign k_next = (LEN_W'(k_q) == len_m1) ? '0 : (k_q + PA_W'(1));

  // Derivation walk and cipher position
  always_comb begin
    i_d         = i_q;
    k_d         = k_q;
    j_d         = j_q;
    c_d         = c_q;
    key_pos_d   = key_pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.apply_start) begin
      i_d = '0;
      k_d = '0;
      j_d = '0;
      c_d = '0;
    end
    if (cmd_i.step) begin
      c_d = (c_q + pass_rdata_q) ^ pass_rdata_q;
      if (!status_o.last_j) begin
        j_d = j_q + PA_W'(1);
      end
    end
    if (cmd_i.key_wb) begin
      i_d = i_q + KA_W'(1);
      k_d = k_next;
      j_d = '0;
      c_d = 8'(k_next);
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      key_pos_d   = (key_raddr_q == KeyLast) ? '0 : (key_raddr_q + KA_W'(1));
    end
  end

  // Control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_pos_q   <= '0;
      out_valid_q <= 1'b0;
      pass_len_q  <= '0;
      key_vld_q   <= '0;
    end else begin
      key_pos_q   <= key_pos_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        pass_len_q <= cfg_wdata_i;
      end
      if (cmd_i.key_wb) begin
        key_vld_q[i_q] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    k_q <= k_d;
    j_q <= j_d;
    c_q <= c_d;
    if (cmd_i.cipher_rd) begin
      value_q <= in_value_i;
    end
    if (cmd_i.out_load) begin
      out_data_q <= value_q ^ key_eff;
    end
  end

  // Key table memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wb) begin
      key_mem[i_q] <= key_eff ^ c_q;
    end
    if (key_re) begin
      key_rdata_q <= key_mem[key_raddr];
      key_rvld_q  <= key_vld_q[key_raddr];
      key_raddr_q <= key_raddr;
    end
  end

  // Password memory, registered read
  always_ff @(posedge clk_i) begin
    if (pass_we) begin
      pass_mem[PA_W'(in_index_i)] <= in_value_i;
    end
    if (pass_re) begin
      pass_rdata_q <= pass_mem[pass_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> hdl/kxbc_checker.sv
`default_nettype none

module kxbc_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic [kxbc_pkg::InDataW-1:0]        s_axis_tdata,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [kxbc_pkg::ByteW-1:0]          m_axis_tdata,
  input wire logic                                cfg_we_i,
  input wire logic [kxbc_pkg::PassLenW-1:0]       cfg_wdata_i
);

  logic in_xfer;
  logic cipher_xfer;
  logic load_xfer;

  assign in_xfer     = s_axis_tvalid && s_axis_tready;
  assign cipher_xfer = in_xfer &&
      (s_axis_tdata[kxbc_pkg::FuncLsb +: kxbc_pkg::FuncW] == kxbc_pkg::FUNC_CIPHER);
  assign load_xfer   = in_xfer &&
      (s_axis_tdata[kxbc_pkg::FuncLsb +: kxbc_pkg::FuncW] == kxbc_pkg::FUNC_LOAD);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Cipher result valid once the key read register and then the result register are loaded
  a_cipher_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cipher_xfer |=> ##1 m_axis_tvalid)
    else $error("cipher result missing");

  // Block is busy right after a cipher transfer
  a_cipher_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cipher_xfer |=> !s_axis_tready)
    else $error("ready during cipher read");

  // A new result only appears for a cipher transfer that went through the key read and result register
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(m_axis_tvalid) |-> $past(cipher_xfer, 2))
    else $error("result without cipher transfer");

  // Password loads never stall the input
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
      load_xfer |=> s_axis_tready)
    else $error("stall after password load");

  logic unused_cfg;
  assign unused_cfg = cfg_we_i ^ (^cfg_wdata_i);

endmodule

bind keyed_xor_byte_cipher_top kxbc_checker u_kxbc_checker (.*);

`default_nettype wire

>>> test/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_LEN     = 32;
  localparam int MAX_PASS    = 32;
  localparam int PHASE_ITEMS = 103;
  localparam int MAX_REPORTS = 10;
  localparam int STALL_LIMIT = 20000;
  // longest derivation walk plus margin
  localparam int SETTLE_CYCLES = KEY_LEN * (MAX_PASS + 1) + 16;

  // selector value the block ignores
  localparam logic [kxbc_pkg::FuncW-1:0] FUNC_NONE = 2'd3;

  // command word, lowest field in the lowest bits
  typedef struct packed {
    logic                          first;
    logic [kxbc_pkg::ByteW-1:0]    value;
    logic [kxbc_pkg::IndexW-1:0]   index;
    logic [kxbc_pkg::FuncW-1:0]    func;
  } cipher_cmd_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [kxbc_pkg::InDataW-1:0]     s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [kxbc_pkg::ByteW-1:0]       m_axis_tdata;
  logic                             cfg_we_i = 1'b0;
  logic [kxbc_pkg::PassLenW-1:0]    cfg_wdata_i = '0;

  // shadow copy of the cipher state
  logic [kxbc_pkg::ByteW-1:0]       shadow_key [KEY_LEN];
  logic [kxbc_pkg::ByteW-1:0]       shadow_pass [MAX_PASS];
  int unsigned                      shadow_pos;
  logic [kxbc_pkg::PassLenW-1:0]    shadow_pass_len;

  cipher_cmd_t                      stim_q [$];
  logic [kxbc_pkg::ByteW-1:0]       cipher_bytes_q [$];
  bit   [MAX_PASS-1:0]              gen_written;
  bit                               steady_run;
  bit                               moved;
  int                               fail_count;
  int                               idle_cycles;
  logic [kxbc_pkg::ByteW-1:0]       want_byte;
  int                               phase_pass_len [7] = '{1, 63, 0, 32, 2, 33, 31};

  keyed_xor_byte_cipher_top #(
    .KEY_LEN  (KEY_LEN),
    .MAX_PASS (MAX_PASS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // one derived key byte: walk the password starting from k
  function automatic logic [7:0] derived_byte(input int k, input int len);
    logic [7:0] c;
    c = k[7:0];
    for (int j = 0; j < len; j++) begin
      c = c + shadow_pass[j];
      c = c ^ shadow_pass[j];
    end
    return c;
  endfunction

  // advance the shadow state by one accepted command
  function automatic void predict_command(input cipher_cmd_t cmd);
    int len;
    len = (shadow_pass_len > MAX_PASS) ? MAX_PASS : int'(shadow_pass_len);
    case (cmd.func)
      kxbc_pkg::FUNC_LOAD: begin
        shadow_pass[cmd.index] = cmd.value;
      end
      kxbc_pkg::FUNC_APPLY: begin
        // empty password leaves the key alone
        if (len != 0) begin
          for (int i = 0; i < KEY_LEN; i++)
            shadow_key[i] ^= derived_byte(i % len, len);
        end
      end
      kxbc_pkg::FUNC_CIPHER: begin
        if (cmd.first) shadow_pos = 0;
        cipher_bytes_q.push_back(cmd.value ^ shadow_key[shadow_pos]);
        shadow_pos = (shadow_pos + 1) % KEY_LEN;
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_command(input logic [kxbc_pkg::FuncW-1:0] f,
                                        input logic [kxbc_pkg::IndexW-1:0] idx,
                                        input logic [kxbc_pkg::ByteW-1:0] v,
                                        input logic f1);
    cipher_cmd_t cmd;
    cmd.func  = f;
    cmd.index = idx;
    cmd.value = v;
    cmd.first = f1;
    if (f == kxbc_pkg::FUNC_LOAD) gen_written[idx] = 1'b1;
    stim_q.push_back(cmd);
  endfunction

  // mostly data bytes; an apply is only issued once the password prefix it
  // reads has been written, otherwise the first missing byte is loaded instead
  function automatic void queue_random_command(input int pass_len);
    int eff;
    int gap;
    int roll;
    logic [kxbc_pkg::FuncW-1:0] f;
    logic [kxbc_pkg::IndexW-1:0] idx;
    eff = (pass_len > MAX_PASS) ? MAX_PASS : pass_len;
    gap = -1;
    for (int j = 0; j < eff; j++)
      if (!gen_written[j] && gap < 0) gap = j;
    roll = int'($urandom_range(99));
    idx  = kxbc_pkg::IndexW'($urandom_range(MAX_PASS - 1));
    if (roll < 66)      f = kxbc_pkg::FUNC_CIPHER;
    else if (roll < 86) f = kxbc_pkg::FUNC_LOAD;
    else if (roll < 93) f = kxbc_pkg::FUNC_APPLY;
    else                f = FUNC_NONE;
    if (f == kxbc_pkg::FUNC_APPLY && gap >= 0) begin
      f   = kxbc_pkg::FUNC_LOAD;
      idx = kxbc_pkg::IndexW'(gap);
    end
    // rare restarts so the key position wraps often
    queue_command(f, idx, kxbc_pkg::ByteW'($urandom_range(255)),
                  (f == kxbc_pkg::FUNC_CIPHER) ? ($urandom_range(99) < 4)
                                               : 1'($urandom_range(1)));
  endfunction

  // all commands taken, all results back, derivation walk finished
  task automatic wait_quiescent();
    while (stim_q.size() != 0 || s_axis_tvalid || cipher_bytes_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_pass_len(input logic [kxbc_pkg::PassLenW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    shadow_pass_len = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // command driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (stim_q.size() != 0 && (steady_run || $urandom_range(99) >= 11)) begin
        s_axis_tdata  <= stim_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= steady_run || ($urandom_range(99) >= 11);
  end

  // transfer monitor, checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_command(s_axis_tdata);
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (cipher_bytes_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected data_out %02h", $realtime, m_axis_tdata);
        end else begin
          want_byte = cipher_bytes_q.pop_front();
          if (m_axis_tdata !== want_byte) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: data_out mismatch, expected %02h got %02h",
                       $realtime, want_byte, m_axis_tdata);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL keyed_xor_byte_cipher_top");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    int len;
    for (int i = 0; i < KEY_LEN; i++)
      shadow_key[i] = 8'(((i * i + i + 1) << 3));
    shadow_pos      = 0;
    shadow_pass_len = '0;
    gen_written     = '0;
    steady_run      = 1'b0;
    fail_count      = 0;
    idle_cycles     = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: field extremes, restarts, ignored selector, empty password
    queue_command(kxbc_pkg::FUNC_CIPHER, 5'd0,  8'h00, 1'b1);
    queue_command(kxbc_pkg::FUNC_CIPHER, 5'd31, 8'hFF, 1'b0);
    queue_command(kxbc_pkg::FUNC_CIPHER, 5'd0,  8'hA5, 1'b0);
    queue_command(kxbc_pkg::FUNC_CIPHER, 5'd31, 8'h5A, 1'b1);
    queue_command(FUNC_NONE,             5'd31, 8'hFF, 1'b1);
    queue_command(kxbc_pkg::FUNC_APPLY,  5'd0,  8'h00, 1'b0);
    queue_command(kxbc_pkg::FUNC_CIPHER, 5'd0,  8'h00, 1'b1);
    queue_command(kxbc_pkg::FUNC_LOAD,   5'd0,  8'h00, 1'b0);
    queue_command(kxbc_pkg::FUNC_LOAD,   5'd31, 8'hFF, 1'b1);
    queue_command(kxbc_pkg::FUNC_LOAD,   5'd0,  8'hFF, 1'b0);
    queue_command(kxbc_pkg::FUNC_APPLY,  5'd31, 8'hFF, 1'b1);
    queue_command(kxbc_pkg::FUNC_CIPHER, 5'd0,  8'hFF, 1'b0);
    queue_command(FUNC_NONE,             5'd0,  8'h00, 1'b0);

    // random phases, one password length each; long ones saturate
    for (int p = 0; p < 10; p++) begin
      wait_quiescent();
      len = (p < 7) ? phase_pass_len[p] : int'($urandom_range(63));
      write_pass_len(len[kxbc_pkg::PassLenW-1:0]);
      steady_run = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++)
        queue_random_command(len);
    end

    wait_quiescent();
    if (fail_count == 0) begin
      $display("PASS keyed_xor_byte_cipher_top");
    end else begin
      $display("FAIL keyed_xor_byte_cipher_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
